// ===== rtl/cenum_pkg.sv =====
`default_nettype none
package cenum_pkg;

  localparam int MAX_PARTS   = 8;
  localparam int PART_BITS   = 8;
  localparam int CNT_W       = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int NPOS_W      = CNT_W + 1;
  localparam int NUM_PARTS_W = 4;
  localparam int LEVEL_W     = 8;
  localparam int VALUE_W     = 8;
  localparam int POS_W       = 3;
  localparam int CFG_DATA_W  = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [PART_BITS-1:0]   part_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [NPOS_W-1:0]      npos_t;
  typedef logic [NUM_PARTS_W-1:0] num_parts_t;
  typedef logic [LEVEL_W-1:0]     level_t;
  typedef logic [VALUE_W-1:0]     value_t;
  typedef logic [POS_W-1:0]       pos_t;
  typedef logic [QPTR_W-1:0]      qptr_t;
  typedef logic [QCNT_W-1:0]      qcnt_t;

  typedef enum logic [0:0] {
    CFG_NUM_PARTS   = 1'b0,
    CFG_TOTAL_LEVEL = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    CMD_ADVANCE = 1'b0,
    CMD_RESTART = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_SCAN,
    BS_DECIDE,
    BS_EMIT
  } bstate_e;

  typedef struct packed {
    logic valid;
    cmd_e cmd;
  } qreq_t;

endpackage
`default_nettype wire

// ===== rtl/cenum_front.sv =====
`default_nettype none
module cenum_front (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    s_valid_i,
  output logic                   s_ready_o,
  input  wire                    restart_i,
  output cenum_pkg::qreq_t       req_o,
  input  wire                    req_ready_i
);

  logic            valid_q, valid_d;
  cenum_pkg::cmd_e cmd_q, cmd_d;

  assign s_ready_o = !valid_q || req_ready_i;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (valid_q && req_ready_i) begin
      valid_d = 1'b0;
    end
    if (s_valid_i && s_ready_o) begin
      valid_d = 1'b1;
      cmd_d   = restart_i ? cenum_pkg::CMD_RESTART : cenum_pkg::CMD_ADVANCE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cmd_q   <= cenum_pkg::CMD_ADVANCE;
    end else begin
      valid_q <= valid_d;
      cmd_q   <= cmd_d;
    end
  end

  assign req_o.valid = valid_q;
  assign req_o.cmd   = cmd_q;

endmodule
`default_nettype wire

// ===== rtl/cenum_fifo.sv =====
`default_nettype none
module cenum_fifo (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  cenum_pkg::qreq_t       wr_i,
  output logic                   wr_ready_o,
  output cenum_pkg::qreq_t       rd_o,
  input  wire                    rd_pop_i
);

  cenum_pkg::cmd_e  mem_q [cenum_pkg::QUEUE_DEPTH];
  cenum_pkg::qptr_t wptr_q, wptr_d, rptr_q, rptr_d;
  cenum_pkg::qcnt_t count_q, count_d;
  logic             push, pop;

  assign wr_ready_o = count_q != cenum_pkg::qcnt_t'(cenum_pkg::QUEUE_DEPTH);
  assign push       = wr_i.valid && wr_ready_o;
  assign pop        = rd_pop_i && (count_q != '0);

  assign rd_o.valid = count_q != '0;
  assign rd_o.cmd   = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (wptr_q == cenum_pkg::qptr_t'(cenum_pkg::QUEUE_DEPTH - 1)) ? '0
             : cenum_pkg::qptr_t'(wptr_q + 1'b1);
    end
    if (pop) begin
      rptr_d = (rptr_q == cenum_pkg::qptr_t'(cenum_pkg::QUEUE_DEPTH - 1)) ? '0
             : cenum_pkg::qptr_t'(rptr_q + 1'b1);
    end
    if (push && !pop) begin
      count_d = cenum_pkg::qcnt_t'(count_q + 1'b1);
    end else if (pop && !push) begin
      count_d = cenum_pkg::qcnt_t'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_i.cmd;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cenum_back.sv =====
`default_nettype none
module cenum_back (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  cenum_pkg::num_parts_t  num_parts_i,
  input  cenum_pkg::level_t      total_level_i,
  input  cenum_pkg::qreq_t       req_i,
  output logic                   req_pop_o,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output cenum_pkg::value_t      out_value_o,
  output cenum_pkg::pos_t        out_pos_o,
  output logic                   out_last_o,
  output logic                   out_more_o
);

  cenum_pkg::bstate_e state_q, state_d;
  cenum_pkg::cnt_t    cnt_q, cnt_d, h_q, h_d, head_q, head_d;
  cenum_pkg::part_t   t_q, t_d, lo_q, lo_d, tail_q, tail_d;
  cenum_pkg::part_t   line_q [cenum_pkg::MAX_PARTS];
  cenum_pkg::part_t   line_d [cenum_pkg::MAX_PARTS];
  logic               first_q, first_d, more_q, more_d;
  logic               ov_q, ov_d;
  cenum_pkg::value_t  val_q, val_d;
  cenum_pkg::pos_t    pos_q, pos_d;
  logic               last_q, last_d, usr_q, usr_d;

  cenum_pkg::npos_t   n_eff, cnt_ext, h_ext, h_adv_ext;
  cenum_pkg::cnt_t    h_adv;
  cenum_pkg::part_t   lvl, slot, new_val, new_last;
  logic               take_first, emit_slot, out_free, step, cnt_last, emit_fire;

  always_comb begin
    if (num_parts_i == '0) begin
      n_eff = cenum_pkg::npos_t'(1);
    end else if (int'(num_parts_i) > cenum_pkg::MAX_PARTS) begin
      n_eff = cenum_pkg::npos_t'(cenum_pkg::MAX_PARTS);
    end else begin
      n_eff = cenum_pkg::npos_t'(num_parts_i);
    end
  end

  assign lvl       = cenum_pkg::part_t'(total_level_i);
  assign slot      = line_q[0];
  assign cnt_ext   = cenum_pkg::npos_t'(cnt_q);
  assign h_ext     = cenum_pkg::npos_t'(h_q);
  assign cnt_last  = cnt_q == cenum_pkg::cnt_t'(cenum_pkg::MAX_PARTS - 1);
  assign h_adv     = (tail_q > cenum_pkg::part_t'(1)) ? '0 : head_q;
  assign h_adv_ext = cenum_pkg::npos_t'(h_adv);
  assign take_first = (req_i.cmd == cenum_pkg::CMD_RESTART) || !more_q
                   || (cenum_pkg::npos_t'(h_adv_ext + 1'b1) >= n_eff);
  assign emit_slot = cnt_ext < n_eff;
  assign out_free  = !ov_q || out_ready_i;
  assign step      = !emit_slot || out_free;
  assign new_last  = (cenum_pkg::npos_t'(n_eff - 1'b1) == cenum_pkg::npos_t'(h_ext + 1'b1))
                   ? cenum_pkg::part_t'(lo_q + 1'b1) : lo_q;

  always_comb begin
    if (first_q) begin
      new_val = (cnt_q == '0) ? lvl : '0;
    end else if (cnt_q == '0) begin
      new_val = cenum_pkg::part_t'(t_q - 1'b1);
    end else if (cnt_q == h_q) begin
      new_val = '0;
    end else if (cnt_ext == cenum_pkg::npos_t'(h_ext + 1'b1)) begin
      new_val = cenum_pkg::part_t'(slot + 1'b1);
    end else begin
      new_val = slot;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cenum_pkg::BS_IDLE: begin
        if (req_i.valid) begin
          state_d = take_first ? cenum_pkg::BS_EMIT : cenum_pkg::BS_SCAN;
        end
      end
      cenum_pkg::BS_SCAN: begin
        if (cnt_last) begin
          state_d = cenum_pkg::BS_DECIDE;
        end
      end
      cenum_pkg::BS_DECIDE: begin
        state_d = cenum_pkg::BS_EMIT;
      end
      cenum_pkg::BS_EMIT: begin
        if (step && cnt_last) begin
          state_d = cenum_pkg::BS_IDLE;
        end
      end
      default: begin
        state_d = cenum_pkg::BS_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    req_pop_o = 1'b0;
    emit_fire = 1'b0;
    unique case (state_q)
      cenum_pkg::BS_IDLE:   req_pop_o = req_i.valid;
      cenum_pkg::BS_EMIT:   emit_fire = emit_slot && out_free;
      default: begin
        req_pop_o = 1'b0;
        emit_fire = 1'b0;
      end
    endcase
  end

  always_comb begin
    cnt_d   = cnt_q;
    h_d     = h_q;
    t_d     = t_q;
    lo_d    = lo_q;
    first_d = first_q;
    head_d  = head_q;
    tail_d  = tail_q;
    more_d  = more_q;
    line_d  = line_q;
    ov_d    = ov_q && !out_ready_i;
    val_d   = val_q;
    pos_d   = pos_q;
    last_d  = last_q;
    usr_d   = usr_q;
    unique case (state_q)
      cenum_pkg::BS_IDLE: begin
        if (req_pop_o) begin
          cnt_d   = '0;
          h_d     = h_adv;
          first_d = take_first;
          if (take_first) begin
            tail_d = lvl;
            head_d = '0;
            more_d = (n_eff == cenum_pkg::npos_t'(1)) ? 1'b0 : (lvl != '0);
          end
        end
      end
      cenum_pkg::BS_SCAN: begin
        if (cnt_q == h_q) begin
          t_d = slot;
        end
        if (cnt_ext == cenum_pkg::npos_t'(n_eff - 1'b1)) begin
          lo_d = slot;
        end
        for (int i = 0; i < cenum_pkg::MAX_PARTS - 1; i++) begin
          line_d[i] = line_q[i+1];
        end
        line_d[cenum_pkg::MAX_PARTS-1] = slot;
        cnt_d = cnt_last ? '0 : cenum_pkg::cnt_t'(cnt_q + 1'b1);
      end
      cenum_pkg::BS_DECIDE: begin
        tail_d = t_q;
        head_d = cenum_pkg::cnt_t'(h_ext + 1'b1);
        more_d = new_last != lvl;
        cnt_d  = '0;
      end
      cenum_pkg::BS_EMIT: begin
        if (step) begin
          for (int i = 0; i < cenum_pkg::MAX_PARTS - 1; i++) begin
            line_d[i] = line_q[i+1];
          end
          line_d[cenum_pkg::MAX_PARTS-1] = new_val;
          cnt_d = cnt_last ? '0 : cenum_pkg::cnt_t'(cnt_q + 1'b1);
        end
        if (emit_fire) begin
          ov_d   = 1'b1;
          val_d  = cenum_pkg::value_t'(new_val);
          pos_d  = cenum_pkg::pos_t'(cnt_q);
          last_d = cnt_ext == cenum_pkg::npos_t'(n_eff - 1'b1);
          usr_d  = more_q;
        end
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cenum_pkg::BS_IDLE;
      cnt_q   <= '0;
      h_q     <= '0;
      t_q     <= '0;
      lo_q    <= '0;
      first_q <= 1'b0;
      head_q  <= '0;
      tail_q  <= '0;
      more_q  <= 1'b0;
      ov_q    <= 1'b0;
      for (int i = 0; i < cenum_pkg::MAX_PARTS; i++) begin
        line_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      h_q     <= h_d;
      t_q     <= t_d;
      lo_q    <= lo_d;
      first_q <= first_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      more_q  <= more_d;
      ov_q    <= ov_d;
      line_q  <= line_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    pos_q  <= pos_d;
    last_q <= last_d;
    usr_q  <= usr_d;
  end

  assign out_valid_o = ov_q;
  assign out_value_o = val_q;
  assign out_pos_o   = pos_q;
  assign out_last_o  = last_q;
  assign out_more_o  = usr_q;

  a_rise_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q == cenum_pkg::BS_EMIT))
    else $error("result appeared outside the emit phase");

  a_pop_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_pop_o |=> (state_q == cenum_pkg::BS_SCAN || state_q == cenum_pkg::BS_EMIT))
    else $error("popped request did not start a scan or an emit sweep");

  a_scan_ends_in_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cenum_pkg::BS_SCAN)
      |=> (state_q == cenum_pkg::BS_SCAN || state_q == cenum_pkg::BS_DECIDE))
    else $error("scan sweep left without a decision step");

endmodule
`default_nettype wire

// ===== rtl/composition_enumerator.sv =====
`default_nettype none
// Each request on the input stream produces one composition of total_level into
// num_parts parts (clamped to 1..MAX_PARTS), delivered as that many output transfers
// (part 0 first, tlast on the final part, tuser set when another composition follows).
// Requests go through a two-entry queue to a unit that keeps the parts in a rotating
// register line: a restart request, or an advance after the last composition, takes
// one sweep of the line to rewrite and send the parts, and an ordinary advance takes
// one sweep to read the head and last parts, a decision step and one sweep to rewrite
// and send them; sending holds while the output side stalls. Configuration writes
// are accepted every cycle and must only be issued while the block is idle.
module composition_enumerator (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire  [7:0]             s_axis_tdata,   // [0] restart, [7:1] zero
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready,
  output logic [15:0]            m_axis_tdata,   // [7:0] part_value, [10:8] part_position
  output logic                   m_axis_tlast,
  output logic                   m_axis_tuser,   // [0] more_follow
  input  wire                    cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire                    cfg_index_i,
  input  wire  [cenum_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  cenum_pkg::num_parts_t num_parts_q;
  cenum_pkg::level_t     total_level_q;
  cenum_pkg::qreq_t      front_req, back_req;
  logic                  q_ready, back_pop;
  cenum_pkg::value_t     out_value;
  cenum_pkg::pos_t       out_pos;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_parts_q   <= cenum_pkg::num_parts_t'(1);
      total_level_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cenum_pkg::cfg_idx_e'(cfg_index_i))
        cenum_pkg::CFG_NUM_PARTS:
          num_parts_q <= cenum_pkg::num_parts_t'(cfg_data_i);
        cenum_pkg::CFG_TOTAL_LEVEL:
          total_level_q <= cenum_pkg::level_t'(cfg_data_i);
        default: begin
          num_parts_q <= num_parts_q;
        end
      endcase
    end
  end

  cenum_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .restart_i   (s_axis_tdata[0]),
    .req_o       (front_req),
    .req_ready_i (q_ready)
  );

  cenum_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (front_req),
    .wr_ready_o (q_ready),
    .rd_o       (back_req),
    .rd_pop_i   (back_pop)
  );

  cenum_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .num_parts_i   (num_parts_q),
    .total_level_i (total_level_q),
    .req_i         (back_req),
    .req_pop_o     (back_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_value_o   (out_value),
    .out_pos_o     (out_pos),
    .out_last_o    (m_axis_tlast),
    .out_more_o    (m_axis_tuser)
  );

  assign m_axis_tdata = {5'b0, out_pos, out_value};

endmodule
`default_nettype wire

// ===== dv/tb_composition_enumerator.sv =====
`timescale 1ns / 1ps

module tb_composition_enumerator;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 6;
  localparam int SETTLE       = 2 * cenum_pkg::MAX_PARTS + 2;
  localparam int RANDOM_ITEMS = 280;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct {
    cenum_pkg::value_t value;
    cenum_pkg::pos_t   position;
    logic              last;
    logic              more;
  } part_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;
  logic              m_axis_tlast;
  logic              m_axis_tuser;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  cenum_pkg::cfg_idx_e cfg_index = cenum_pkg::CFG_NUM_PARTS;
  logic [cenum_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  // Mirror of the configuration and of the enumeration state.
  cenum_pkg::num_parts_t num_parts_q;
  cenum_pkg::level_t     level_q;
  cenum_pkg::part_t      parts_q [cenum_pkg::MAX_PARTS];
  int                    head_q;
  cenum_pkg::part_t      tail_q;
  logic                  more_q;

  part_result_t pending_parts[$];
  part_result_t got_part;
  int  fail_count;
  int  requests_sent;
  int  cycle_count;
  int  rx_stall_left;
  bit  tx_idle_en;
  bit  rx_idle_en;

  composition_enumerator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int random_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(0, 3);
  endfunction

  always @(posedge clk_i) begin
    if (rx_stall_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left--;
    end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left = random_gap();
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_parts.size() == 0) begin
        $error("unexpected part: value %0d position %0d", m_axis_tdata[7:0],
               m_axis_tdata[10:8]);
        fail_count++;
      end else begin
        got_part = pending_parts.pop_front();
        if (m_axis_tdata[7:0] !== got_part.value) begin
          $error("part_value: expected %0d, got %0d", got_part.value, m_axis_tdata[7:0]);
          fail_count++;
        end
        if (m_axis_tdata[10:8] !== got_part.position) begin
          $error("part_position: expected %0d, got %0d", got_part.position,
                 m_axis_tdata[10:8]);
          fail_count++;
        end
        if (m_axis_tlast !== got_part.last) begin
          $error("last_part: expected %0d, got %0d", got_part.last, m_axis_tlast);
          fail_count++;
        end
        if (m_axis_tuser !== got_part.more) begin
          $error("more_follow: expected %0d, got %0d", got_part.more, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  function automatic int active_parts();
    if (num_parts_q == 0) return 1;
    if (num_parts_q > cenum_pkg::MAX_PARTS) return cenum_pkg::MAX_PARTS;
    return int'(num_parts_q);
  endfunction

  function automatic void load_first_composition();
    foreach (parts_q[d]) parts_q[d] = '0;
    parts_q[0] = cenum_pkg::part_t'(level_q);
    tail_q     = cenum_pkg::part_t'(level_q);
    head_q     = 0;
  endfunction

  // Steps the mirrored enumeration and queues the parts it should produce.
  function automatic void advance_composition(cenum_pkg::cmd_e cmd);
    int               n;
    int               h;
    cenum_pkg::part_t t;
    part_result_t     r;
    n = active_parts();
    if (cmd == cenum_pkg::CMD_RESTART || !more_q) begin
      load_first_composition();
    end else begin
      h = (tail_q > 1) ? 0 : head_q;
      if (h + 1 >= n) begin
        load_first_composition();
      end else begin
        t = parts_q[h];
        parts_q[h] = '0;
        parts_q[0] = t - 1'b1;
        parts_q[h + 1] = parts_q[h + 1] + 1'b1;
        tail_q = t;
        head_q = h + 1;
      end
    end
    more_q = (parts_q[n - 1] != cenum_pkg::part_t'(level_q));
    for (int k = 0; k < n; k++) begin
      r.value    = cenum_pkg::value_t'(parts_q[k]);
      r.position = cenum_pkg::pos_t'(k);
      r.last     = (k == n - 1);
      r.more     = more_q;
      pending_parts.push_back(r);
    end
  endfunction

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_parts.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic send_request(input cenum_pkg::cmd_e cmd);
    int gap;
    gap = tx_idle_en ? random_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    advance_composition(cmd);
    requests_sent++;
  endtask

  task automatic write_register(input cenum_pkg::cfg_idx_e idx,
                                input logic [cenum_pkg::CFG_DATA_W-1:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index   <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == cenum_pkg::CFG_NUM_PARTS) num_parts_q = value[3:0];
    else level_q = value;
  endtask

  task automatic test_after_reset();
    send_request(cenum_pkg::CMD_ADVANCE);
    send_request(cenum_pkg::CMD_RESTART);
  endtask

  task automatic test_part_count_limits();
    write_register(cenum_pkg::CFG_TOTAL_LEVEL, 8'd3);
    write_register(cenum_pkg::CFG_NUM_PARTS, 8'h00);
    send_request(cenum_pkg::CMD_RESTART);
    send_request(cenum_pkg::CMD_ADVANCE);
    write_register(cenum_pkg::CFG_NUM_PARTS, 8'h0F);
    send_request(cenum_pkg::CMD_RESTART);
    send_request(cenum_pkg::CMD_ADVANCE);
    send_request(cenum_pkg::CMD_ADVANCE);
    write_register(cenum_pkg::CFG_NUM_PARTS, 8'hF9);
    send_request(cenum_pkg::CMD_RESTART);
    send_request(cenum_pkg::CMD_ADVANCE);
  endtask

  task automatic test_level_extremes();
    write_register(cenum_pkg::CFG_NUM_PARTS, 8'd8);
    write_register(cenum_pkg::CFG_TOTAL_LEVEL, 8'd255);
    send_request(cenum_pkg::CMD_RESTART);
    repeat (3) send_request(cenum_pkg::CMD_ADVANCE);
    write_register(cenum_pkg::CFG_TOTAL_LEVEL, 8'd0);
    send_request(cenum_pkg::CMD_RESTART);
    send_request(cenum_pkg::CMD_ADVANCE);
    write_register(cenum_pkg::CFG_NUM_PARTS, 8'd2);
    write_register(cenum_pkg::CFG_TOTAL_LEVEL, 8'd1);
    send_request(cenum_pkg::CMD_RESTART);
    repeat (2) send_request(cenum_pkg::CMD_ADVANCE);
  endtask

  task automatic test_inconsistent_advance();
    write_register(cenum_pkg::CFG_NUM_PARTS, 8'd4);
    write_register(cenum_pkg::CFG_TOTAL_LEVEL, 8'd3);
    send_request(cenum_pkg::CMD_RESTART);
    repeat (3) send_request(cenum_pkg::CMD_ADVANCE);
    write_register(cenum_pkg::CFG_NUM_PARTS, 8'd2);
    send_request(cenum_pkg::CMD_ADVANCE);
    write_register(cenum_pkg::CFG_TOTAL_LEVEL, 8'd9);
    send_request(cenum_pkg::CMD_ADVANCE);
  endtask

  task automatic test_random_walks();
    int  walk_len;
    bit  paced;
    bit  first_phase;
    logic [3:0] count;
    logic [7:0] level;
    first_phase = 1'b1;
    while (requests_sent < RANDOM_ITEMS - 20) begin
      case ($urandom_range(0, 9))
        0:       count = 4'd0;
        1:       count = 4'd8;
        2:       count = 4'($urandom_range(9, 15));
        default: count = 4'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 4))
        0:       level = 8'($urandom_range(0, 255));
        1:       level = 8'($urandom_range(7, 40));
        default: level = 8'($urandom_range(0, 6));
      endcase
      write_register(cenum_pkg::CFG_NUM_PARTS, {4'($urandom_range(0, 15)), count});
      write_register(cenum_pkg::CFG_TOTAL_LEVEL, level);
      paced      = first_phase || ($urandom_range(0, 7) == 0);
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      walk_len   = $urandom_range(5, 40);
      if ($urandom_range(0, 3) != 0) send_request(cenum_pkg::CMD_RESTART);
      repeat (walk_len) begin
        if (paced) wait_drained();
        if ($urandom_range(0, 24) == 0) begin
          if ($urandom_range(0, 1) == 0)
            write_register(cenum_pkg::CFG_NUM_PARTS, 8'($urandom_range(0, 15)));
          else
            write_register(cenum_pkg::CFG_TOTAL_LEVEL, 8'($urandom_range(0, 12)));
        end
        send_request(($urandom_range(0, 11) == 0) ? cenum_pkg::CMD_RESTART
                                                  : cenum_pkg::CMD_ADVANCE);
      end
      first_phase = 1'b0;
    end
  endtask

  initial begin
    num_parts_q   = 4'd1;
    level_q       = '0;
    foreach (parts_q[d]) parts_q[d] = '0;
    head_q        = 0;
    tail_q        = '0;
    more_q        = 1'b0;
    fail_count    = 0;
    requests_sent = 0;
    cycle_count   = 0;
    rx_stall_left = 0;
    tx_idle_en    = 1'b0;
    rx_idle_en    = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_after_reset();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_part_count_limits();
    test_level_extremes();
    test_inconsistent_advance();
    test_random_walks();

    wait_drained();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== composition_enumerator.f =====
rtl/cenum_pkg.sv
rtl/cenum_front.sv
rtl/cenum_fifo.sv
rtl/cenum_back.sv
rtl/composition_enumerator.sv
dv/tb_composition_enumerator.sv
